// File: design/breakpoint_gain_ramp_defines.svh
// Assertion macros shared by the breakpoint_gain_ramp RTL.
// Expects signals named clock and reset in the including module.
`ifndef BREAKPOINT_GAIN_RAMP_DEFINES_SVH
`define BREAKPOINT_GAIN_RAMP_DEFINES_SVH

// same-cycle implication, off while reset is high
`define BGR_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, also checked across reset
`define BGR_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/bgr_pkg.sv
// Shared types, constants and the control-store program for breakpoint_gain_ramp.
// No dependencies; used by every module of the block.
package bgr_pkg;

   localparam int DEF_MAX_POINTS = 256;
   localparam int DEF_INDEX_BITS = 24;

   localparam int OPCODE_W  = 2;
   localparam int SAMPLE_W  = 16;
   localparam int FACTOR_W  = 24;
   localparam int GAIN_W    = 32;
   localparam int ENTRY_W   = 2 * FACTOR_W;
   localparam int PROD_W    = 48;
   localparam int CSR_IDX_W = 2;
   localparam int DIV_CNT_W = $clog2(GAIN_W);
   localparam int PC_W      = 5;

   localparam logic [GAIN_W-1:0]   ONE_Q824   = 32'h0100_0000;
   localparam logic [FACTOR_W-1:0] FACTOR_MAX = 24'hFF_FFFF;

   // request opcodes
   localparam logic [OPCODE_W-1:0] OPC_LOAD    = 2'd0;
   localparam logic [OPCODE_W-1:0] OPC_SAMPLE  = 2'd1;
   localparam logic [OPCODE_W-1:0] OPC_RESTART = 2'd2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CLAMP_ENABLE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_FACTOR   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_FACTOR   = 2'd2;

   typedef enum logic [3:0] {
      UOP_NOP,
      UOP_FETCH,
      UOP_RD_FIRST,
      UOP_START,
      UOP_MUL,
      UOP_EMIT,
      UOP_RD_NEXT,
      UOP_DIV_INIT,
      UOP_DIV_STEP,
      UOP_RAMP,
      UOP_JUMP,
      UOP_ADVANCE,
      UOP_END,
      UOP_EMIT_PASS,
      UOP_LOAD,
      UOP_CLEAR
   } uop_type;

   typedef enum logic [3:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_REQ,
      COND_OP_LOAD,
      COND_OP_RESTART,
      COND_NOT_SAMPLE,
      COND_PASS,
      COND_STARTED,
      COND_RSP_BUSY,
      COND_IN_SEG,
      COND_LAST,
      COND_NOT_AHEAD,
      COND_DIV_MORE
   } cond_type;

   typedef struct packed {
      uop_type           uop;
      cond_type          cond;
      logic [PC_W-1:0]   target;
   } ctrl_word_type;

   // datapath flags seen by the sequencer
   typedef struct packed {
      logic req_valid;
      logic op_load;
      logic op_restart;
      logic op_sample;
      logic pass;
      logic started;
      logic rsp_busy;
      logic in_seg;
      logic last;
      logic not_ahead;
      logic div_more;
   } stat_type;

   typedef struct packed {
      logic start;
      logic step;
   } div_ctl_type;

   // program addresses
   localparam logic [PC_W-1:0] ST_FETCH     = 5'd0;
   localparam logic [PC_W-1:0] ST_DEC_LOAD  = 5'd1;
   localparam logic [PC_W-1:0] ST_DEC_RST   = 5'd2;
   localparam logic [PC_W-1:0] ST_DEC_SMP   = 5'd3;
   localparam logic [PC_W-1:0] ST_CHK_PASS  = 5'd4;
   localparam logic [PC_W-1:0] ST_RD_FIRST  = 5'd5;
   localparam logic [PC_W-1:0] ST_START     = 5'd6;
   localparam logic [PC_W-1:0] ST_MUL       = 5'd7;
   localparam logic [PC_W-1:0] ST_EMIT      = 5'd8;
   localparam logic [PC_W-1:0] ST_CHK_SEG   = 5'd9;
   localparam logic [PC_W-1:0] ST_CHK_LAST  = 5'd10;
   localparam logic [PC_W-1:0] ST_RD_NEXT   = 5'd11;
   localparam logic [PC_W-1:0] ST_CHK_AHEAD = 5'd12;
   localparam logic [PC_W-1:0] ST_DIV_INIT  = 5'd13;
   localparam logic [PC_W-1:0] ST_DIV_LOOP  = 5'd14;
   localparam logic [PC_W-1:0] ST_DIV_DONE  = 5'd15;
   localparam logic [PC_W-1:0] ST_JUMP      = 5'd16;
   localparam logic [PC_W-1:0] ST_ADVANCE   = 5'd17;
   localparam logic [PC_W-1:0] ST_END       = 5'd18;
   localparam logic [PC_W-1:0] ST_PASS      = 5'd19;
   localparam logic [PC_W-1:0] ST_PASS_RET  = 5'd20;
   localparam logic [PC_W-1:0] ST_LOAD      = 5'd21;
   localparam logic [PC_W-1:0] ST_RESTART   = 5'd22;
   localparam logic [PC_W-1:0] ST_LAST      = ST_RESTART;

   // control store: taken condition jumps to target, otherwise falls through
   function automatic ctrl_word_type ucode_rom(input logic [PC_W-1:0] pc);
      ctrl_word_type cw;
      cw = '{uop: UOP_NOP, cond: COND_ALWAYS, target: ST_FETCH};
      case (pc)
         ST_FETCH:     cw = '{UOP_FETCH,     COND_NO_REQ,     ST_FETCH};
         ST_DEC_LOAD:  cw = '{UOP_NOP,       COND_OP_LOAD,    ST_LOAD};
         ST_DEC_RST:   cw = '{UOP_NOP,       COND_OP_RESTART, ST_RESTART};
         ST_DEC_SMP:   cw = '{UOP_NOP,       COND_NOT_SAMPLE, ST_FETCH};
         ST_CHK_PASS:  cw = '{UOP_NOP,       COND_PASS,       ST_PASS};
         ST_RD_FIRST:  cw = '{UOP_RD_FIRST,  COND_STARTED,    ST_MUL};
         ST_START:     cw = '{UOP_START,     COND_NEVER,      ST_FETCH};
         ST_MUL:       cw = '{UOP_MUL,       COND_NEVER,      ST_FETCH};
         ST_EMIT:      cw = '{UOP_EMIT,      COND_RSP_BUSY,   ST_EMIT};
         ST_CHK_SEG:   cw = '{UOP_NOP,       COND_IN_SEG,     ST_ADVANCE};
         ST_CHK_LAST:  cw = '{UOP_NOP,       COND_LAST,       ST_END};
         ST_RD_NEXT:   cw = '{UOP_RD_NEXT,   COND_NEVER,      ST_FETCH};
         ST_CHK_AHEAD: cw = '{UOP_NOP,       COND_NOT_AHEAD,  ST_JUMP};
         ST_DIV_INIT:  cw = '{UOP_DIV_INIT,  COND_NEVER,      ST_FETCH};
         ST_DIV_LOOP:  cw = '{UOP_DIV_STEP,  COND_DIV_MORE,   ST_DIV_LOOP};
         ST_DIV_DONE:  cw = '{UOP_RAMP,      COND_ALWAYS,     ST_ADVANCE};
         ST_JUMP:      cw = '{UOP_JUMP,      COND_NEVER,      ST_FETCH};
         ST_ADVANCE:   cw = '{UOP_ADVANCE,   COND_ALWAYS,     ST_FETCH};
         ST_END:       cw = '{UOP_END,       COND_ALWAYS,     ST_FETCH};
         ST_PASS:      cw = '{UOP_EMIT_PASS, COND_RSP_BUSY,   ST_PASS};
         ST_PASS_RET:  cw = '{UOP_NOP,       COND_ALWAYS,     ST_FETCH};
         ST_LOAD:      cw = '{UOP_LOAD,      COND_ALWAYS,     ST_FETCH};
         ST_RESTART:   cw = '{UOP_CLEAR,     COND_ALWAYS,     ST_FETCH};
         default:      cw = '{UOP_NOP,       COND_ALWAYS,     ST_FETCH};
      endcase
      return cw;
   endfunction

endpackage

// File: design/breakpoint_gain_ramp.sv
// breakpoint_gain_ramp scales signed 16-bit samples by a gain that follows a loaded
// breakpoint contour; a small microcode program in bgr_seq drives the datapath in bgr_dp.
// One request is worked at a time, and a new one is taken while the last result
// still waits in the output register. The program works each request in steps: a load
// stores one point while the table has room, a restart empties the contour; a sample
// is scaled by the ramped gain, and at a segment boundary the next point is read and
// the gain jumps to it if it is not ahead, else ramps toward it by a step from the
// one-bit-per-cycle divider. Pass-through samples go out unscaled. Each result waits
// in the emit step while the output is stalled. No clearing pass follows reset.
module breakpoint_gain_ramp #(
   parameter int MAX_POINTS = bgr_pkg::DEF_MAX_POINTS,
   parameter int INDEX_BITS = bgr_pkg::DEF_INDEX_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [bgr_pkg::OPCODE_W-1:0]        req_opcode,
   input  logic signed [bgr_pkg::SAMPLE_W-1:0] req_sample_in,
   input  logic [bgr_pkg::FACTOR_W-1:0]        req_point_end,
   input  logic [bgr_pkg::FACTOR_W-1:0]        req_point_gain,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [bgr_pkg::SAMPLE_W-1:0] rsp_sample_out,
   output logic                                rsp_contour_done,
   input  logic                                csr_we,
   input  logic [bgr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bgr_pkg::FACTOR_W-1:0]        csr_wdata
);
   import bgr_pkg::*;

   uop_type  uop;
   stat_type stat;

   bgr_seq u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .uop   (uop)
   );

   bgr_dp #(
      .MAX_POINTS (MAX_POINTS),
      .INDEX_BITS (INDEX_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .uop              (uop),
      .stat             (stat),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_sample_in    (req_sample_in),
      .req_point_end    (req_point_end),
      .req_point_gain   (req_point_gain),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sample_out   (rsp_sample_out),
      .rsp_contour_done (rsp_contour_done),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

endmodule

// File: design/bgr_seq.sv
// Microcode sequencer: step counter, control-store lookup and branch condition.
// Depends on bgr_pkg and breakpoint_gain_ramp_defines.svh.
`include "breakpoint_gain_ramp_defines.svh"

module bgr_seq (
   input  logic              clock,
   input  logic              reset,
   input  bgr_pkg::stat_type stat,
   output bgr_pkg::uop_type  uop
);
   import bgr_pkg::*;

   logic [PC_W-1:0] pc_ff;
   logic [PC_W-1:0] pc_in;
   ctrl_word_type   cw;
   logic            take;

   assign cw  = ucode_rom(pc_ff);
   assign uop = cw.uop;

   always_comb begin
      case (cw.cond)
         COND_NEVER:      take = 1'b0;
         COND_ALWAYS:     take = 1'b1;
         COND_NO_REQ:     take = !stat.req_valid;
         COND_OP_LOAD:    take = stat.op_load;
         COND_OP_RESTART: take = stat.op_restart;
         COND_NOT_SAMPLE: take = !stat.op_sample;
         COND_PASS:       take = stat.pass;
         COND_STARTED:    take = stat.started;
         COND_RSP_BUSY:   take = stat.rsp_busy;
         COND_IN_SEG:     take = stat.in_seg;
         COND_LAST:       take = stat.last;
         COND_NOT_AHEAD:  take = stat.not_ahead;
         COND_DIV_MORE:   take = stat.div_more;
         default:         take = 1'b0;
      endcase
   end

   assign pc_in = take ? cw.target : pc_ff + PC_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= ST_FETCH;
      end else begin
         pc_ff <= pc_in;
      end
   end

   `BGR_ASSERT_NXT(a_reset_to_fetch, reset, pc_ff == ST_FETCH, "pc not at fetch after reset")
   `BGR_ASSERT_IMP(a_pc_in_program, 1'b1, pc_ff <= ST_LAST, "pc outside program")
   `BGR_ASSERT_NXT(a_fetch_waits, !reset && pc_ff == ST_FETCH && !stat.req_valid, pc_ff == ST_FETCH, "left fetch without request")

endmodule

// File: design/bgr_div.sv
// Restoring divider, one quotient bit per step, unsigned magnitudes.
// Depends on bgr_pkg.
module bgr_div (
   input  logic                          clock,
   input  logic                          reset,
   input  bgr_pkg::div_ctl_type          ctl,
   input  logic [bgr_pkg::GAIN_W-1:0]    dividend,
   input  logic [bgr_pkg::FACTOR_W-1:0]  divisor,
   output logic [bgr_pkg::GAIN_W-1:0]    quotient,
   output logic                          more
);
   import bgr_pkg::*;

   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(GAIN_W - 1);

   logic [DIV_CNT_W-1:0] cnt_ff,  cnt_in;
   logic [GAIN_W-1:0]    dq_ff,   dq_in;
   logic [FACTOR_W-1:0]  rem_ff,  rem_in;
   logic [FACTOR_W-1:0]  dvs_ff,  dvs_in;
   logic [FACTOR_W:0]    trial;
   logic [FACTOR_W:0]    diff;
   logic                 fits;

   assign trial = {rem_ff, dq_ff[GAIN_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      cnt_in = cnt_ff;
      dq_in  = dq_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      if (ctl.start) begin
         cnt_in = DIV_LAST;
         dq_in  = dividend;
         rem_in = '0;
         dvs_in = divisor;
      end else if (ctl.step) begin
         rem_in = fits ? diff[FACTOR_W-1:0] : trial[FACTOR_W-1:0];
         dq_in  = {dq_ff[GAIN_W-2:0], fits};
         if (cnt_ff != '0) begin
            cnt_in = cnt_ff - DIV_CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign quotient = dq_ff;
   assign more     = cnt_ff != '0;

endmodule

// File: design/bgr_dp.sv
// Datapath: request latch, breakpoint table, gain ramp registers, multiplier,
// result register and config registers. Depends on bgr_pkg, bgr_div and the defines header.
`include "breakpoint_gain_ramp_defines.svh"

module bgr_dp #(
   parameter int MAX_POINTS = bgr_pkg::DEF_MAX_POINTS,
   parameter int INDEX_BITS = bgr_pkg::DEF_INDEX_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  bgr_pkg::uop_type                    uop,
   output bgr_pkg::stat_type                   stat,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [bgr_pkg::OPCODE_W-1:0]        req_opcode,
   input  logic signed [bgr_pkg::SAMPLE_W-1:0] req_sample_in,
   input  logic [bgr_pkg::FACTOR_W-1:0]        req_point_end,
   input  logic [bgr_pkg::FACTOR_W-1:0]        req_point_gain,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [bgr_pkg::SAMPLE_W-1:0] rsp_sample_out,
   output logic                                rsp_contour_done,
   input  logic                                csr_we,
   input  logic [bgr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bgr_pkg::FACTOR_W-1:0]        csr_wdata
);
   import bgr_pkg::*;

   localparam int AW     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CW     = AW + 1;
   localparam int CMP_W  = (INDEX_BITS > FACTOR_W) ? INDEX_BITS : FACTOR_W;
   localparam logic [CW-1:0] CNT_MAX = CW'(MAX_POINTS);
   localparam logic [SAMPLE_W-1:0] SAT_POS = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic [SAMPLE_W-1:0] SAT_NEG = {1'b1, {(SAMPLE_W-1){1'b0}}};

   // config
   logic                clamp_ff, clamp_in;
   logic [FACTOR_W-1:0] max_ff,   max_in;
   logic [FACTOR_W-1:0] min_ff,   min_in;

   // latched request
   logic [OPCODE_W-1:0]        opcode_ff, opcode_in;
   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;
   logic [FACTOR_W-1:0]        pend_ff,   pend_in;
   logic [FACTOR_W-1:0]        pgain_ff,  pgain_in;

   // contour state
   logic [CW-1:0]         point_count_ff,   point_count_in;
   logic [CW-1:0]         current_point_ff, current_point_in;
   logic [INDEX_BITS-1:0] sample_index_ff,  sample_index_in;
   logic [GAIN_W-1:0]     gain_acc_ff,      gain_acc_in;
   logic [GAIN_W-1:0]     gain_step_ff,     gain_step_in;
   logic [FACTOR_W-1:0]   segment_end_ff,   segment_end_in;
   logic                  ended_ff,         ended_in;
   logic                  div_neg_ff,       div_neg_in;
   logic [PROD_W-1:0]     prod_ff,          prod_in;

   // result register
   logic                rsp_valid_ff,  rsp_valid_in;
   logic [SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;
   logic                rsp_done_ff,   rsp_done_in;

   // breakpoint table, {end, gain}
   logic [ENTRY_W-1:0]  point_mem [MAX_POINTS];
   logic [ENTRY_W-1:0]  mem_q_ff;
   logic                mem_we, mem_re;
   logic [AW-1:0]       mem_waddr, mem_raddr;
   logic [ENTRY_W-1:0]  mem_wdata;
   logic [FACTOR_W-1:0] mem_end, mem_gain;

   logic [FACTOR_W-1:0] gain_hi, gain_clamped;
   logic [CMP_W-1:0]    idx_ext, seg_ext, new_end_ext, len_full;
   logic [GAIN_W-1:0]   target;
   logic [GAIN_W:0]     diff, diff_neg;
   logic [GAIN_W-1:0]   div_mag;
   logic [GAIN_W-1:0]   quotient;
   logic                div_more;
   div_ctl_type         div_ctl;
   logic signed [PROD_W:0] prod_full;
   logic [PROD_W-1:0]   prod_mag;
   logic [FACTOR_W-1:0] scaled_mag;
   logic [SAMPLE_W-1:0] scaled;
   logic                rsp_busy;
   logic                fetch;

   assign mem_end  = mem_q_ff[ENTRY_W-1:FACTOR_W];
   assign mem_gain = mem_q_ff[FACTOR_W-1:0];

   // max test first, then min
   assign gain_hi      = (clamp_ff && pgain_ff > max_ff) ? max_ff : pgain_ff;
   assign gain_clamped = (clamp_ff && gain_hi < min_ff) ? min_ff : gain_hi;

   assign idx_ext     = CMP_W'(sample_index_ff);
   assign seg_ext     = CMP_W'(segment_end_ff);
   assign new_end_ext = CMP_W'(mem_end);
   assign len_full    = new_end_ext - idx_ext;

   assign target   = {mem_gain, 8'h00};
   assign diff     = {1'b0, target} - {1'b0, gain_acc_ff};
   assign diff_neg = ~diff + (GAIN_W+1)'(1);
   assign div_mag  = diff[GAIN_W] ? diff_neg[GAIN_W-1:0] : diff[GAIN_W-1:0];

   assign div_ctl.start = (uop == UOP_DIV_INIT);
   assign div_ctl.step  = (uop == UOP_DIV_STEP);

   bgr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend (div_mag),
      .divisor  (len_full[FACTOR_W-1:0]),
      .quotient (quotient),
      .more     (div_more)
   );

   assign prod_full = sample_ff * $signed({1'b0, gain_acc_ff});

   // truncate toward zero, then saturate
   assign prod_mag   = prod_ff[PROD_W-1] ? (~prod_ff + PROD_W'(1)) : prod_ff;
   assign scaled_mag = prod_mag[PROD_W-1:24];
   always_comb begin
      if (prod_ff[PROD_W-1]) begin
         if (scaled_mag >= FACTOR_W'(SAT_NEG)) begin
            scaled = SAT_NEG;
         end else begin
            scaled = ~scaled_mag[SAMPLE_W-1:0] + SAMPLE_W'(1);
         end
      end else begin
         if (scaled_mag > FACTOR_W'(SAT_POS)) begin
            scaled = SAT_POS;
         end else begin
            scaled = scaled_mag[SAMPLE_W-1:0];
         end
      end
   end

   assign rsp_busy  = rsp_valid_ff && rsp_stall;
   assign fetch     = (uop == UOP_FETCH);
   assign req_stall = !fetch;

   always_comb begin
      clamp_in = clamp_ff;
      max_in   = max_ff;
      min_in   = min_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_CLAMP_ENABLE: clamp_in = csr_wdata[0];
            CSR_MAX_FACTOR:   max_in   = csr_wdata;
            CSR_MIN_FACTOR:   min_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      opcode_in        = opcode_ff;
      sample_in        = sample_ff;
      pend_in          = pend_ff;
      pgain_in         = pgain_ff;
      point_count_in   = point_count_ff;
      current_point_in = current_point_ff;
      sample_index_in  = sample_index_ff;
      gain_acc_in      = gain_acc_ff;
      gain_step_in     = gain_step_ff;
      segment_end_in   = segment_end_ff;
      ended_in         = ended_ff;
      div_neg_in       = div_neg_ff;
      prod_in          = prod_ff;
      rsp_valid_in     = rsp_busy;
      rsp_sample_in    = rsp_sample_ff;
      rsp_done_in      = rsp_done_ff;
      mem_we           = 1'b0;
      mem_waddr        = point_count_ff[AW-1:0];
      mem_wdata        = {pend_ff, gain_clamped};
      mem_re           = 1'b0;
      mem_raddr        = current_point_ff[AW-1:0];
      case (uop)
         UOP_FETCH: begin
            if (req_valid) begin
               opcode_in = req_opcode;
               sample_in = req_sample_in;
               pend_in   = req_point_end;
               pgain_in  = req_point_gain;
            end
         end
         UOP_RD_FIRST: begin
            mem_re    = 1'b1;
            mem_raddr = '0;
         end
         UOP_START: begin
            gain_acc_in      = target;
            gain_step_in     = '0;
            segment_end_in   = mem_end;
            current_point_in = CW'(1);
         end
         UOP_MUL: begin
            prod_in = prod_full[PROD_W-1:0];
         end
         UOP_EMIT: begin
            if (!rsp_busy) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = scaled;
               rsp_done_in   = 1'b0;
            end
         end
         UOP_RD_NEXT: begin
            mem_re = 1'b1;
         end
         UOP_DIV_INIT: begin
            div_neg_in = diff[GAIN_W];
         end
         UOP_RAMP: begin
            gain_step_in     = div_neg_ff ? (~quotient + GAIN_W'(1)) : quotient;
            segment_end_in   = mem_end;
            current_point_in = current_point_ff + CW'(1);
         end
         UOP_JUMP: begin
            gain_acc_in      = target;
            gain_step_in     = '0;
            segment_end_in   = mem_end;
            current_point_in = current_point_ff + CW'(1);
         end
         UOP_ADVANCE: begin
            gain_acc_in     = gain_acc_ff + gain_step_ff;
            sample_index_in = sample_index_ff + INDEX_BITS'(1);
         end
         UOP_END: begin
            ended_in = 1'b1;
         end
         UOP_EMIT_PASS: begin
            if (!rsp_busy) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = sample_ff;
               rsp_done_in   = 1'b1;
            end
         end
         UOP_LOAD: begin
            if (point_count_ff < CNT_MAX) begin
               mem_we         = 1'b1;
               point_count_in = point_count_ff + CW'(1);
            end
         end
         UOP_CLEAR: begin
            point_count_in   = '0;
            current_point_in = '0;
            sample_index_in  = '0;
            gain_acc_in      = ONE_Q824;
            gain_step_in     = '0;
            segment_end_in   = '0;
            ended_in         = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         point_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_q_ff <= point_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clamp_ff         <= 1'b0;
         max_ff           <= FACTOR_MAX;
         min_ff           <= '0;
         point_count_ff   <= '0;
         current_point_ff <= '0;
         sample_index_ff  <= '0;
         gain_acc_ff      <= ONE_Q824;
         gain_step_ff     <= '0;
         segment_end_ff   <= '0;
         ended_ff         <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         clamp_ff         <= clamp_in;
         max_ff           <= max_in;
         min_ff           <= min_in;
         point_count_ff   <= point_count_in;
         current_point_ff <= current_point_in;
         sample_index_ff  <= sample_index_in;
         gain_acc_ff      <= gain_acc_in;
         gain_step_ff     <= gain_step_in;
         segment_end_ff   <= segment_end_in;
         ended_ff         <= ended_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      opcode_ff     <= opcode_in;
      sample_ff     <= sample_in;
      pend_ff       <= pend_in;
      pgain_ff      <= pgain_in;
      div_neg_ff    <= div_neg_in;
      prod_ff       <= prod_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_done_ff   <= rsp_done_in;
   end

   assign stat.req_valid  = req_valid;
   assign stat.op_load    = (opcode_ff == OPC_LOAD);
   assign stat.op_restart = (opcode_ff == OPC_RESTART);
   assign stat.op_sample  = (opcode_ff == OPC_SAMPLE);
   assign stat.pass       = (point_count_ff == '0) || ended_ff;
   assign stat.started    = (current_point_ff != '0);
   assign stat.rsp_busy   = rsp_busy;
   assign stat.in_seg     = idx_ext < seg_ext;
   assign stat.last       = current_point_ff >= point_count_ff;
   assign stat.not_ahead  = !(new_end_ext > idx_ext);
   assign stat.div_more   = div_more;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sample_out   = rsp_sample_ff;
   assign rsp_contour_done = rsp_done_ff;

   `BGR_ASSERT_IMP(a_count_bound, 1'b1, point_count_ff <= CNT_MAX, "point count above table depth")
   `BGR_ASSERT_IMP(a_cursor_bound, 1'b1, current_point_ff <= point_count_ff, "cursor past loaded points")
   `BGR_ASSERT_IMP(a_ended_started, ended_ff, current_point_ff != '0, "ended without contour start")
   `BGR_ASSERT_IMP(a_rsp_from_emit, $rose(rsp_valid_ff), $past(uop) == UOP_EMIT || $past(uop) == UOP_EMIT_PASS, "response without emit step")

endmodule
